/* sv/priority_task_queue_core_assert.svh */
// Assertion macros for the priority task queue core.
// No dependencies; included by files that carry concurrent checks.
`ifndef PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH
`define PRIORITY_TASK_QUEUE_CORE_ASSERT_SVH

// same-cycle implication
`define PTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ptq_pkg.sv */
// Shared types and constants for the priority task queue core.
// No dependencies; imported by ptq_cell and priority_task_queue_core.
package ptq_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  localparam logic [3:0] MAX_PRIO = 4'd9;
  localparam logic [6:0] MAX_RUNS = 7'd99;
  localparam logic [6:0] MIN_RUNS = 7'd1;

  typedef enum logic [2:0] {
    FN_INSERT   = 3'd0,
    FN_RUN_HEAD = 3'd1,
    FN_RUN_ID   = 3'd2,
    FN_REMOVE   = 3'd3,
    FN_SET_PRIO = 3'd4
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD       = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_INSERT,
    WR_DEC,
    WR_REMOVE,
    WR_SET_PRIO
  } wr_op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] task_id;
    logic [3:0]  priority_req;
    logic [6:0]  runs;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] result_id;
    logic [6:0]  remaining;
    logic        finished;
    logic [4:0]  occupancy;
  } out_item_t;

  // search record flags carried cell to cell
  typedef struct packed {
    logic       head_found;
    logic [6:0] head_key;   // larger is better under either policy
    logic [6:0] head_rem;
    logic       match_found;
    logic [6:0] match_rem;
    logic       free_found;
  } scan_flags_t;

  // write-back command broadcast to every cell
  typedef struct packed {
    wr_op_t     op;
    logic [3:0] prio;
    logic [6:0] rem;
  } wr_cmd_t;

endpackage

/* sv/ptq_cell.sv */
// One queue slot: holds a task and updates the passing search record.
// Depends on ptq_pkg.
module ptq_cell import ptq_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF,
  parameter int IDX     = 0,
  localparam int SLOT_W = $clog2(DEPTH),
  localparam int CNT_W  = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               policy,
  input  logic [15:0]        req_id,
  input  scan_flags_t        flags_i,
  input  logic [SLOT_W-1:0]  head_slot_i,
  input  logic [ID_BITS-1:0] head_id_i,
  input  logic [SLOT_W-1:0]  match_slot_i,
  input  logic [SLOT_W-1:0]  free_slot_i,
  input  logic [CNT_W-1:0]   count_i,
  output scan_flags_t        flags_o,
  output logic [SLOT_W-1:0]  head_slot_o,
  output logic [ID_BITS-1:0] head_id_o,
  output logic [SLOT_W-1:0]  match_slot_o,
  output logic [SLOT_W-1:0]  free_slot_o,
  output logic [CNT_W-1:0]   count_o,
  input  wr_cmd_t            wr_cmd,
  input  logic [SLOT_W-1:0]  wr_slot,
  input  logic [ID_BITS-1:0] wr_id
);

  localparam int CMP_W = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  logic               valid_r, valid_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [3:0]         prio_r, prio_nxt;
  logic [6:0]         rem_r, rem_nxt;

  scan_flags_t        flags_r, flags_nxt;
  logic [SLOT_W-1:0]  head_slot_r, head_slot_nxt;
  logic [ID_BITS-1:0] head_id_r, head_id_nxt;
  logic [SLOT_W-1:0]  match_slot_r, match_slot_nxt;
  logic [SLOT_W-1:0]  free_slot_r, free_slot_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  logic [6:0] key;
  logic       better;
  logic       id_hit;
  logic [6:0] rem_dec;

  // fewest runs first maps to the inverted count so that larger always wins
  assign key    = policy ? ~rem_r : {3'b000, prio_r};
  assign better = !flags_i.head_found || (key > flags_i.head_key) ||
                  ((key == flags_i.head_key) && (id_r > head_id_i));
  assign id_hit = (CMP_W'(id_r) == CMP_W'(req_id));
  assign rem_dec = (rem_r != 7'd0) ? rem_r - 7'd1 : 7'd0;

  always_comb begin
    flags_nxt      = flags_i;
    head_slot_nxt  = head_slot_i;
    head_id_nxt    = head_id_i;
    match_slot_nxt = match_slot_i;
    free_slot_nxt  = free_slot_i;
    count_nxt      = count_i + CNT_W'(valid_r);
    if (valid_r && better) begin
      flags_nxt.head_found = 1'b1;
      flags_nxt.head_key   = key;
      flags_nxt.head_rem   = rem_r;
      head_slot_nxt        = MY_SLOT;
      head_id_nxt          = id_r;
    end
    if (valid_r && id_hit && !flags_i.match_found) begin
      flags_nxt.match_found = 1'b1;
      flags_nxt.match_rem   = rem_r;
      match_slot_nxt        = MY_SLOT;
    end
    if (!valid_r && !flags_i.free_found) begin
      flags_nxt.free_found = 1'b1;
      free_slot_nxt        = MY_SLOT;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    prio_nxt  = prio_r;
    rem_nxt   = rem_r;
    if (wr_slot == MY_SLOT) begin
      case (wr_cmd.op)
        WR_INSERT: begin
          valid_nxt = 1'b1;
          id_nxt    = wr_id;
          prio_nxt  = wr_cmd.prio;
          rem_nxt   = wr_cmd.rem;
        end
        WR_DEC: begin
          rem_nxt = rem_dec;
          if (rem_dec == 7'd0) begin
            valid_nxt = 1'b0;
          end
        end
        WR_REMOVE:   valid_nxt = 1'b0;
        WR_SET_PRIO: prio_nxt  = wr_cmd.prio;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flags_r <= flags_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    prio_r       <= prio_nxt;
    rem_r        <= rem_nxt;
    head_slot_r  <= head_slot_nxt;
    head_id_r    <= head_id_nxt;
    match_slot_r <= match_slot_nxt;
    free_slot_r  <= free_slot_nxt;
  end

  assign flags_o      = flags_r;
  assign head_slot_o  = head_slot_r;
  assign head_id_o    = head_id_r;
  assign match_slot_o = match_slot_r;
  assign free_slot_o  = free_slot_r;
  assign count_o      = count_r;

endmodule

/* sv/priority_task_queue_core.sv */
// Priority task queue: a chain of DEPTH task cells scanned by a moving
// search record, then a write-back to the chosen cell. Depends on ptq_pkg,
// ptq_cell and priority_task_queue_core_assert.svh.
//
// Usage:
//   in_valid/in_ready/in_item carry one command transaction (insert, run
//   head, run by id, remove, set priority). out_valid/out_ready/out_item
//   return exactly one result transaction per command.
//   cfg_we/cfg_wdata write order_policy (0 highest priority first, 1 fewest
//   remaining runs first); write it only while the block is idle.
// Timing:
//   A command is accepted in the idle state; the search record walks the
//   chain one cell per cycle, then the write-back state updates the chosen
//   cell and loads the output register. The result is presented from that
//   register once write-back is done, and the next command is taken only in
//   the idle state that follows, also while the previous result is still
//   waiting.
// Reset:
//   All slots empty, id counter zero, policy zero, no result pending.
// Stall:
//   If a result is still held when the next write-back is due, the block
//   waits in write-back until out_ready frees the output register.
module priority_task_queue_core import ptq_pkg::*; #(
  parameter int DEPTH   = DEPTH_DEF,
  parameter int ID_BITS = ID_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

`include "priority_task_queue_core_assert.svh"

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = (CNT_W > 5) ? CNT_W : 5;
  localparam int RID_W  = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [SLOT_W-1:0] LAST_STEP = SLOT_W'(DEPTH - 1);

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  step_r, step_nxt;
  logic               policy_r;
  logic [ID_BITS-1:0] next_id_r, next_id_nxt;
  in_item_t           req_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  wr_cmd_t            wr_cmd;
  logic [SLOT_W-1:0]  wr_slot;
  logic [ID_BITS-1:0] wr_id;
  logic               commit_go;

  // search record at each point of the chain; index 0 is the seed
  scan_flags_t        flags_c      [DEPTH+1];
  logic [SLOT_W-1:0]  head_slot_c  [DEPTH+1];
  logic [ID_BITS-1:0] head_id_c    [DEPTH+1];
  logic [SLOT_W-1:0]  match_slot_c [DEPTH+1];
  logic [SLOT_W-1:0]  free_slot_c  [DEPTH+1];
  logic [CNT_W-1:0]   count_c      [DEPTH+1];

  assign flags_c[0]      = '0;
  assign head_slot_c[0]  = '0;
  assign head_id_c[0]    = '0;
  assign match_slot_c[0] = '0;
  assign free_slot_c[0]  = '0;
  assign count_c[0]      = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ptq_cell #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS),
      .IDX     (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .policy       (policy_r),
      .req_id       (req_r.task_id),
      .flags_i      (flags_c[g]),
      .head_slot_i  (head_slot_c[g]),
      .head_id_i    (head_id_c[g]),
      .match_slot_i (match_slot_c[g]),
      .free_slot_i  (free_slot_c[g]),
      .count_i      (count_c[g]),
      .flags_o      (flags_c[g+1]),
      .head_slot_o  (head_slot_c[g+1]),
      .head_id_o    (head_id_c[g+1]),
      .match_slot_o (match_slot_c[g+1]),
      .free_slot_o  (free_slot_c[g+1]),
      .count_o      (count_c[g+1]),
      .wr_cmd       (wr_cmd),
      .wr_slot      (wr_slot),
      .wr_id        (wr_id)
    );
  end

  scan_flags_t        fl;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   occ;
  logic [ID_BITS-1:0] id_inc;
  logic [RID_W-1:0]   rid_ext;
  logic [6:0]         rem_dec;
  logic               bad_ins;

  assign fl      = flags_c[DEPTH];
  assign cnt     = count_c[DEPTH];
  assign id_inc  = next_id_r + ID_BITS'(1);
  assign bad_ins = (req_r.priority_req > MAX_PRIO) || (req_r.runs < MIN_RUNS) ||
                   (req_r.runs > MAX_RUNS);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);

  // result and write-back, decided from the record leaving the last cell
  always_comb begin
    wr_cmd      = '{op: WR_NONE, prio: req_r.priority_req, rem: req_r.runs};
    wr_slot     = '0;
    wr_id       = id_inc;
    next_id_nxt = next_id_r;
    occ         = cnt;
    rid_ext     = '0;
    rem_dec     = '0;
    out_item_nxt           = '0;
    out_item_nxt.status    = ST_OK;
    case (req_r.func)
      FN_INSERT: begin
        if (bad_ins) begin
          out_item_nxt.status = ST_BAD;
        end else if (!fl.free_found) begin
          out_item_nxt.status = ST_FULL;
        end else begin
          wr_cmd.op   = WR_INSERT;
          wr_slot     = free_slot_c[DEPTH];
          next_id_nxt = id_inc;
          occ         = cnt + CNT_W'(1);
          rid_ext     = RID_W'(id_inc);
          out_item_nxt.remaining = req_r.runs;
        end
      end
      FN_RUN_HEAD: begin
        if (!fl.head_found) begin
          out_item_nxt.status = ST_EMPTY;
        end else begin
          wr_cmd.op = WR_DEC;
          wr_slot   = head_slot_c[DEPTH];
          rem_dec   = (fl.head_rem != 7'd0) ? fl.head_rem - 7'd1 : 7'd0;
          rid_ext   = RID_W'(head_id_c[DEPTH]);
          out_item_nxt.remaining = rem_dec;
          out_item_nxt.finished  = (rem_dec == 7'd0);
          occ = cnt - CNT_W'(rem_dec == 7'd0);
        end
      end
      FN_RUN_ID: begin
        if (!fl.match_found) begin
          out_item_nxt.status = ST_NOT_FOUND;
        end else begin
          wr_cmd.op = WR_DEC;
          wr_slot   = match_slot_c[DEPTH];
          rem_dec   = (fl.match_rem != 7'd0) ? fl.match_rem - 7'd1 : 7'd0;
          rid_ext   = RID_W'(req_r.task_id);
          out_item_nxt.remaining = rem_dec;
          out_item_nxt.finished  = (rem_dec == 7'd0);
          occ = cnt - CNT_W'(rem_dec == 7'd0);
        end
      end
      FN_REMOVE: begin
        if (!fl.match_found) begin
          out_item_nxt.status = ST_NOT_FOUND;
        end else begin
          wr_cmd.op = WR_REMOVE;
          wr_slot   = match_slot_c[DEPTH];
          rid_ext   = RID_W'(req_r.task_id);
          occ       = cnt - CNT_W'(1);
        end
      end
      FN_SET_PRIO: begin
        if (req_r.priority_req > MAX_PRIO) begin
          out_item_nxt.status = ST_BAD;
        end else if (!fl.match_found) begin
          out_item_nxt.status = ST_NOT_FOUND;
        end else begin
          wr_cmd.op = WR_SET_PRIO;
          wr_slot   = match_slot_c[DEPTH];
          rid_ext   = RID_W'(req_r.task_id);
          out_item_nxt.remaining = fl.match_rem;
        end
      end
      default: out_item_nxt.status = ST_BAD;
    endcase
    out_item_nxt.result_id = rid_ext[15:0];
    out_item_nxt.occupancy = 5'(OCC_W'(occ));
    if (!commit_go) begin
      wr_cmd.op   = WR_NONE;
      next_id_nxt = next_id_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        step_nxt = step_r + SLOT_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      policy_r    <= 1'b0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_item;
    end
    if (commit_go) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PTQ_ASSERT_NXT(a_accept_starts_scan, clk, rst_n, in_valid && in_ready,
                  state_r == S_SCAN, "accepted command did not start a scan")
  `PTQ_ASSERT_NXT(a_commit_loads_out, clk, rst_n, commit_go,
                  out_valid_r && state_r == S_IDLE,
                  "write-back did not present a result")
  `PTQ_ASSERT_NXT(a_id_advance, clk, rst_n, commit_go && wr_cmd.op == WR_INSERT,
                  next_id_r == ID_BITS'($past(next_id_r) + ID_BITS'(1)),
                  "id counter did not advance on insert")
  `PTQ_ASSERT_IMP(a_no_write_outside_commit, clk, rst_n, state_r != S_COMMIT,
                  wr_cmd.op == WR_NONE, "cell write outside write-back")

endmodule

/* tb/priority_task_queue_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for priority_task_queue_core: directed and random command
// traffic, an in-bench model of the task table, and random stalls on both channels.
// Depends on ptq_pkg and the priority_task_queue_core RTL.
module priority_task_queue_core_tb import ptq_pkg::*; ();

  localparam logic [2:0] FN_UNUSED_LO = 3'd5;
  localparam logic [2:0] FN_UNUSED_HI = 3'd7;
  localparam int         HOLD_CYCLES  = 400;

  // Mirror of the task table plus the queue of results still owed by the block.
  class task_table_book;
    bit          policy;
    bit          slot_used [DEPTH_DEF];
    logic [15:0] slot_id   [DEPTH_DEF];
    logic [3:0]  slot_prio [DEPTH_DEF];
    logic [6:0]  slot_runs [DEPTH_DEF];
    logic [15:0] last_id;
    out_item_t   awaited[$];
    int unsigned errors;

    function new();
      int i;
      policy  = 1'b0;
      last_id = '0;
      errors  = 0;
      for (i = 0; i < DEPTH_DEF; i++) begin
        slot_used[i] = 1'b0;
        slot_id[i]   = '0;
        slot_prio[i] = '0;
        slot_runs[i] = '0;
      end
    endfunction

    function int slot_of(logic [15:0] id);
      int i;
      for (i = 0; i < DEPTH_DEF; i++) begin
        if (slot_used[i] && slot_id[i] == id) return i;
      end
      return -1;
    endfunction

    function logic [15:0] live_id();
      logic [15:0] ids[$];
      int i;
      for (i = 0; i < DEPTH_DEF; i++) begin
        if (slot_used[i]) ids.push_back(slot_id[i]);
      end
      if (ids.size() == 0) return 16'($urandom);
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    function out_item_t predict(in_item_t cmd);
      out_item_t r;
      int s, i, n;
      bit wins;
      r = '0;
      r.status = ST_OK;
      s = -1;
      case (cmd.func)
        FN_INSERT: begin
          if (cmd.priority_req > MAX_PRIO || cmd.runs < MIN_RUNS || cmd.runs > MAX_RUNS) begin
            r.status = ST_BAD;
          end else begin
            for (i = DEPTH_DEF - 1; i >= 0; i--) begin
              if (!slot_used[i]) s = i;
            end
            if (s < 0) begin
              r.status = ST_FULL;
            end else begin
              last_id      = last_id + 16'd1;
              slot_used[s] = 1'b1;
              slot_id[s]   = last_id;
              slot_prio[s] = cmd.priority_req;
              slot_runs[s] = cmd.runs;
              r.result_id  = last_id;
              r.remaining  = cmd.runs;
            end
          end
        end
        FN_RUN_HEAD, FN_RUN_ID: begin
          if (cmd.func == FN_RUN_HEAD) begin
            // strict comparison while walking upwards keeps full ties on the lowest slot
            for (i = 0; i < DEPTH_DEF; i++) begin
              if (slot_used[i]) begin
                if (s < 0) begin
                  wins = 1'b1;
                end else if (policy && slot_runs[i] != slot_runs[s]) begin
                  wins = slot_runs[i] < slot_runs[s];
                end else if (!policy && slot_prio[i] != slot_prio[s]) begin
                  wins = slot_prio[i] > slot_prio[s];
                end else begin
                  wins = slot_id[i] > slot_id[s];
                end
                if (wins) s = i;
              end
            end
          end else begin
            s = slot_of(cmd.task_id);
          end
          if (s < 0) begin
            if (cmd.func == FN_RUN_HEAD) r.status = ST_EMPTY;
            else r.status = ST_NOT_FOUND;
          end else begin
            if (slot_runs[s] > 0) slot_runs[s] = slot_runs[s] - 7'd1;
            r.result_id = slot_id[s];
            r.remaining = slot_runs[s];
            if (slot_runs[s] == 0) begin
              slot_used[s] = 1'b0;
              r.finished   = 1'b1;
            end
          end
        end
        FN_REMOVE: begin
          s = slot_of(cmd.task_id);
          if (s < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            slot_used[s] = 1'b0;
            r.result_id  = slot_id[s];
          end
        end
        FN_SET_PRIO: begin
          // priority range is checked ahead of the lookup
          if (cmd.priority_req > MAX_PRIO) begin
            r.status = ST_BAD;
          end else begin
            s = slot_of(cmd.task_id);
            if (s < 0) begin
              r.status = ST_NOT_FOUND;
            end else begin
              slot_prio[s] = cmd.priority_req;
              r.result_id  = slot_id[s];
              r.remaining  = slot_runs[s];
            end
          end
        end
        default: r.status = ST_BAD;
      endcase
      n = 0;
      for (i = 0; i < DEPTH_DEF; i++) begin
        if (slot_used[i]) n++;
      end
      r.occupancy = 5'(n);
      return r;
    endfunction

    function void note_command(in_item_t cmd);
      awaited.push_back(predict(cmd));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void flag(string field, logic [15:0] want_v, logic [15:0] got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing outstanding, status %0d id %0d",
                 $time, got.status, got.result_id);
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status)       flag("status", want.status, got.status);
      if (got.result_id !== want.result_id) flag("result_id", want.result_id, got.result_id);
      if (got.remaining !== want.remaining) flag("remaining", want.remaining, got.remaining);
      if (got.finished !== want.finished)   flag("finished", want.finished, got.finished);
      if (got.occupancy !== want.occupancy) flag("occupancy", want.occupancy, got.occupancy);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we    = 1'b0;
  logic      cfg_wdata = 1'b0;

  task_table_book book = new();
  int  burst_left    = 0;
  bit  hold_off_req  = 1'b0;

  priority_task_queue_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) book.check_result(out_item);
  end

  function automatic in_item_t make_cmd(logic [2:0] fn, logic [15:0] id, logic [3:0] prio,
                                        logic [6:0] runs);
    in_item_t c;
    c.func         = fn;
    c.task_id      = id;
    c.priority_req = prio;
    c.runs         = runs;
    return c;
  endfunction

  // Mostly well-formed commands aimed at live tasks, with a little noise.
  function automatic in_item_t random_command(int insert_pct);
    in_item_t c;
    int roll;
    c = make_cmd(FN_INSERT, book.live_id(), 4'($urandom_range(0, 9)),
                 7'($urandom_range(1, 6)));
    if ($urandom_range(0, 9) == 0) c.runs = 7'($urandom_range(7, 99));
    if ($urandom_range(0, 99) < 8) c.task_id = 16'($urandom);
    roll = $urandom_range(0, 99);
    if (roll >= insert_pct) begin
      roll = $urandom_range(0, 99);
      if (roll < 30)      c.func = FN_RUN_HEAD;
      else if (roll < 55) c.func = FN_RUN_ID;
      else if (roll < 72) c.func = FN_REMOVE;
      else if (roll < 90) c.func = FN_SET_PRIO;
      else c = make_cmd(3'($urandom_range(0, 7)), 16'($urandom), 4'($urandom),
                        7'($urandom));
    end
    return c;
  endfunction

  task automatic send_command(input in_item_t cmd);
    in_valid <= 1'b1;
    in_item  <= cmd;
    do @(posedge clk); while (!in_ready);
    book.note_command(cmd);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  // stop offering until every outstanding result transaction is back
  task automatic settle();
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_policy(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    book.policy = v;
  endtask

  task automatic random_phase(input int count, input int insert_pct, input bit pause_midway);
    int n;
    for (n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) settle();
      send_command(random_command(insert_pct));
    end
  endtask

  initial begin : sink_pattern
    int span, style, k;
    forever begin
      if (hold_off_req) begin
        // long back-pressure so the block fills and stops taking commands
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        span  = $urandom_range(10, 80);
        style = $urandom_range(0, 3);
        for (k = 0; k < span; k++) begin
          case (style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= k[0];
            2:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int i;
    logic [6:0] runs_i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_policy(1'b0);

    // empty table, bad values and unknown functions
    send_command(make_cmd(FN_RUN_HEAD, 16'h0000, 4'd0, 7'd0));
    send_command(make_cmd(FN_RUN_ID, 16'h0000, 4'd0, 7'd0));
    send_command(make_cmd(FN_REMOVE, 16'hFFFF, 4'd0, 7'd0));
    send_command(make_cmd(FN_SET_PRIO, 16'h0001, MAX_PRIO, 7'd0));
    send_command(make_cmd(FN_SET_PRIO, 16'h0001, 4'hF, 7'd5));
    send_command(make_cmd(FN_UNUSED_LO, 16'hA5A5, 4'd3, 7'd3));
    send_command(make_cmd(FN_UNUSED_HI, 16'h5A5A, MAX_PRIO, MAX_RUNS));
    send_command(make_cmd(FN_INSERT, 16'h0000, 4'd10, 7'd5));
    send_command(make_cmd(FN_INSERT, 16'h0000, 4'd0, 7'd0));
    send_command(make_cmd(FN_INSERT, 16'hFFFF, MAX_PRIO, 7'd100));
    send_command(make_cmd(FN_INSERT, 16'hFFFF, 4'hF, 7'd127));

    // fill the table, repeated priorities force id tie-breaks, then overflow it
    for (i = 0; i < DEPTH_DEF; i++) begin
      if (i == 0)      runs_i = MAX_RUNS;
      else if (i == 1) runs_i = MIN_RUNS;
      else             runs_i = 7'((i * 13) % 99 + 1);
      send_command(make_cmd(FN_INSERT, 16'($urandom), 4'((i * 7) % 10), runs_i));
    end
    send_command(make_cmd(FN_INSERT, 16'h0000, 4'd0, MIN_RUNS));
    send_command(make_cmd(FN_RUN_HEAD, 16'h0000, 4'd0, 7'd0));
    send_command(make_cmd(FN_RUN_ID, 16'd2, 4'd0, 7'd0));
    send_command(make_cmd(FN_REMOVE, 16'd3, 4'd0, 7'd0));
    send_command(make_cmd(FN_SET_PRIO, 16'd4, MAX_PRIO, 7'd0));
    send_command(make_cmd(FN_RUN_HEAD, 16'h0000, 4'd0, 7'd0));
    settle();

    write_policy(1'b1);
    hold_off_req = 1'b1;
    random_phase(250, 40, 1'b1);
    settle();

    // insert-heavy to keep running into a full table
    write_policy(1'b0);
    random_phase(250, 60, 1'b0);
    settle();

    write_policy(1'b1);
    random_phase(250, 45, 1'b0);
    settle();

    repeat (40) @(posedge clk);
    if (book.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("run timed out with %0d result transactions outstanding", book.pending());
    $display("Verification failed");
    $finish;
  end

endmodule
